### sv/sorted_option_table_assert.svh
// Assertion macros for the sorted option table.
// Included by the top level; no other dependencies.
`ifndef SORTED_OPTION_TABLE_ASSERT_SVH
`define SORTED_OPTION_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define SOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled during reset
`define SOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SOT_ASSERT_NOW(label, ante, cons)
`define SOT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/sot_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the sorted option table.
// Used by sot_cell and sorted_option_table; no dependencies.
package sot_pkg;

    // option number classes
    localparam logic [4:0] OPT_INVALID     = 5'd0;
    localparam logic [4:0] OPT_LAST_VALUED = 5'd15;
    localparam logic [4:0] OPT_EMPTY       = 5'd21;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // word kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // one table entry
    typedef struct packed {
        logic [4:0]  num;
        logic [3:0]  len;
        logic [63:0] value;
    } entry_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic       ins;        // insert new entry this cycle
        entry_t     ins_entry;  // entry being inserted
        logic [4:0] find_num;   // number searched by a lookup
    } cell_ctl_t;

    // keep the low len bytes
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            m[8*b +: 8] = {8{len > 4'(b)}};
        end
        return m;
    endfunction

endpackage

### sv/sot_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted option table: holds an entry, shifts from its
// lower neighbor on insert. Depends on sot_pkg.
module sot_cell
(
    input  logic              clk,
    input  sot_pkg::cell_ctl_t ctl,
    input  sot_pkg::entry_t   prev,        // lower neighbor's entry
    input  logic              prev_valid,
    input  logic              own_valid,
    output sot_pkg::entry_t   entry,
    output logic              match
);

    sot_pkg::entry_t entry_reg;
    sot_pkg::entry_t entry_next;
    logic            own_gt;
    logic            prev_gt;

    // slot is at or past the insertion point
    assign own_gt  = !own_valid || (entry_reg.num > ctl.ins_entry.num);
    assign prev_gt = prev_valid && (prev.num > ctl.ins_entry.num);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && own_gt)
        begin
            entry_next = prev_gt ? prev : ctl.ins_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = own_valid && (entry_reg.num == ctl.find_num);

endmodule

### sv/sorted_option_table.sv
`timescale 1ns / 1ps
// Insert: accept moves the FSM from idle to push, which loads the result word register.
// Lookup: accept moves the FSM through a find state over the cell row, then to push.
// A new word is taken only in idle, once push has loaded the previous result word.
// A stalled output holds the FSM in its push state until the word is taken.
// Reset (rst_n low, async) empties the table; entry contents are not cleared.
// Top level of the sorted option table; depends on sot_pkg, sot_cell and the assert header.
module sorted_option_table
#(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // option_number[4:0], value_length[8:5],
                                  // value_bytes[72:9], occurrence[76:73]
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // status[1:0], found[2], found_length[6:3],
                                  // found_value[70:7], entry_count[75:71]
);

`include "sorted_option_table_assert.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FIND = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]          count_reg;
    logic                   kind_reg;
    logic [1:0]             status_reg;
    logic [4:0]             q_num_reg;
    logic [3:0]             q_occ_reg;
    logic [TABLE_DEPTH-1:0] tgt_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic                   out_found_reg;
    logic [3:0]             out_len_reg;
    logic [63:0]            out_value_reg;
    logic [4:0]             out_count_reg;

    // input fields
    logic        in_kind;
    logic [4:0]  in_num;
    logic [3:0]  in_len;
    logic [63:0] in_value;
    logic [3:0]  in_occ;
    logic        accept;

    assign in_kind  = s_tuser;
    assign in_num   = s_tdata[4:0];
    assign in_len   = s_tdata[8:5];
    assign in_value = s_tdata[72:9];
    assign in_occ   = s_tdata[76:73];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // insert checks
    logic       valued, empty, full, ins_ok;
    logic [1:0] ins_status;

    assign valued = (in_num != sot_pkg::OPT_INVALID) && (in_num <= sot_pkg::OPT_LAST_VALUED);
    assign empty  = (in_num == sot_pkg::OPT_EMPTY);
    assign full   = (count_reg >= CW'(TABLE_DEPTH));

    always_comb
    begin
        if (!valued && !empty)
            ins_status = sot_pkg::ST_INVALID;
        else if (valued && (in_len > 4'(VALUE_BYTES)))
            ins_status = sot_pkg::ST_TOO_LONG;
        else if (full)
            ins_status = sot_pkg::ST_FULL;
        else
            ins_status = sot_pkg::ST_OK;
    end

    assign ins_ok = accept && (in_kind == sot_pkg::KIND_INSERT) &&
                    (ins_status == sot_pkg::ST_OK);

    // broadcast to the cell row
    sot_pkg::cell_ctl_t ctl;

    always_comb
    begin
        ctl.ins = ins_ok;
        if (empty)
        begin
            ctl.ins_entry.num   = in_num;
            ctl.ins_entry.len   = 4'd0;
            ctl.ins_entry.value = 64'd0;
        end
        else
        begin
            ctl.ins_entry.num   = in_num;
            ctl.ins_entry.len   = in_len;
            ctl.ins_entry.value = in_value & sot_pkg::byte_mask(in_len);
        end
        ctl.find_num = q_num_reg;
    end

    // cell row
    sot_pkg::entry_t        entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid;
    logic [TABLE_DEPTH-1:0] match;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign valid[gi] = (count_reg > CW'(gi));
            if (gi == 0)
            begin : g_first
                sot_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl),
                    .prev       ('0),
                    .prev_valid (1'b0),
                    .own_valid  (valid[gi]),
                    .entry      (entries[gi]),
                    .match      (match[gi])
                );
            end
            else
            begin : g_rest
                sot_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl),
                    .prev       (entries[gi-1]),
                    .prev_valid (valid[gi-1]),
                    .own_valid  (valid[gi]),
                    .entry      (entries[gi]),
                    .match      (match[gi])
                );
            end
        end
    endgenerate

    // run start marks, shifted by the occurrence, pick the target slot
    logic [TABLE_DEPTH-1:0] run_start;
    logic [TABLE_DEPTH-1:0] tgt_next;

    assign run_start = match & ~(match << 1);
    assign tgt_next  = match & (run_start << q_occ_reg);

    // one-hot select of the target entry
    logic [3:0]  sel_len;
    logic [63:0] sel_value;

    always_comb
    begin
        sel_len   = '0;
        sel_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_len   = sel_len   | ({4{tgt_reg[i]}} & entries[i].len);
            sel_value = sel_value | ({64{tgt_reg[i]}} & entries[i].value);
        end
    end

    // control FSM
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (in_kind == sot_pkg::KIND_LOOKUP) ? S_FIND : S_PUSH;
            end
            S_FIND:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            tgt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ins_ok)
                count_reg <= count_reg + CW'(1);
            if (accept)
                tgt_reg <= '0;
            else if (state_reg == S_FIND)
                tgt_reg <= tgt_next;
            if ((state_reg == S_PUSH) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= in_kind;
            status_reg <= ins_status;
            q_num_reg  <= in_num;
            q_occ_reg  <= in_occ;
        end
        if ((state_reg == S_PUSH) && out_free)
        begin
            out_count_reg <= 5'(count_reg);
            if (kind_reg == sot_pkg::KIND_LOOKUP)
            begin
                out_status_reg <= sot_pkg::ST_OK;
                out_found_reg  <= |tgt_reg;
                out_len_reg    <= sel_len;
                out_value_reg  <= sel_value;
            end
            else
            begin
                out_status_reg <= status_reg;
                out_found_reg  <= 1'b0;
                out_len_reg    <= 4'd0;
                out_value_reg  <= 64'd0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_value_reg, out_len_reg,
                       out_found_reg, out_status_reg};

    // checks
    `SOT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `SOT_ASSERT_NEXT(a_insert_grows, ins_ok, count_reg == $past(count_reg) + CW'(1))
    `SOT_ASSERT_NOW(a_target_single, state_reg == S_PUSH, $onehot0(tgt_reg))
    `SOT_ASSERT_NOW(a_found_ok, out_valid_reg && out_found_reg, out_status_reg == sot_pkg::ST_OK)

endmodule
